// ===== hdl/eas_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eas_pkg
// Shared types and constants of the edge angle sorter.
// ----------------------------------------------------------------------------
package eas_pkg;

  localparam int MaxEdgesDefault  = 64;
  localparam int NodeBitsDefault  = 10;
  localparam int CoordBitsDefault = 16;
  localparam int PosBits          = 6;

  // Controller states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_READ,
    ST_SORT_CMP,
    ST_EMIT
  } eas_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic store_edge;
    logic set_overflow;
    logic start_sort;
    logic load_cur;
    logic read_prev;
    logic shift_order;
    logic place_cur;
    logic next_outer;
    logic start_emit;
    logic emit_step;
    logic clear_set;
  } eas_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic full;
    logic outer_done;
    logic inner_at_zero;
    logic prev_greater;
    logic emit_last;
  } eas_status_t;

endpackage
`default_nettype wire

// ===== hdl/eas_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eas_stream_if
// Valid/ready channel carrying one word of payload type T.
// ----------------------------------------------------------------------------
interface eas_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/eas_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eas_datapath
// Edge store, order table and angle comparator of the sorter.
// ----------------------------------------------------------------------------
module eas_datapath #(
  parameter int MAX_EDGES  = eas_pkg::MaxEdgesDefault,
  parameter int NODE_BITS  = eas_pkg::NodeBitsDefault,
  parameter int COORD_BITS = eas_pkg::CoordBitsDefault
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire eas_pkg::eas_cmd_t        cmd,
  output eas_pkg::eas_status_t          status,
  input  wire logic [NODE_BITS-1:0]     in_src,
  input  wire logic signed [COORD_BITS-1:0] in_x,
  input  wire logic signed [COORD_BITS-1:0] in_y,
  output logic [eas_pkg::PosBits-1:0]   out_pos,
  output logic                          out_ovf
);
  localparam int IdxBits = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CntBits = $clog2(MAX_EDGES + 1);
  localparam int EntBits = NODE_BITS + 2 * COORD_BITS;
  localparam int ProdBits = 2 * COORD_BITS;

  logic [EntBits-1:0] store_mem [MAX_EDGES];
  logic [IdxBits-1:0] order_mem [MAX_EDGES];

  logic [CntBits-1:0] count;
  logic               ovf;
  logic [CntBits-1:0] outer;
  logic [IdxBits-1:0] inner;
  logic [IdxBits-1:0] prev_pos;
  logic [EntBits-1:0] cur_ent;
  logic [EntBits-1:0] prev_ent;
  logic [CntBits-1:0] emit_idx;
  logic [IdxBits-1:0] emit_pos;

  // Counters and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      outer <= '0;
      emit_idx <= '0;
    end else begin
      if (cmd.store_edge) count <= count + 1'b1;
      if (cmd.set_overflow) ovf <= 1'b1;
      if (cmd.start_sort) outer <= '0;
      if (cmd.next_outer) outer <= outer + 1'b1;
      if (cmd.start_emit) emit_idx <= '0;
      if (cmd.emit_step) emit_idx <= emit_idx + 1'b1;
      if (cmd.clear_set) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  // Edge store write, order table updates, and current entry and order reads.
  always_ff @(posedge clk) begin
    if (cmd.store_edge) begin
      store_mem[count[IdxBits-1:0]] <= {in_src, in_x, in_y};
    end
    if (cmd.load_cur) begin
      cur_ent <= store_mem[outer[IdxBits-1:0]];
      inner   <= outer[IdxBits-1:0];
    end
    if (cmd.read_prev) begin
      prev_pos <= order_mem[inner - 1'b1];
    end
    if (cmd.shift_order) begin
      order_mem[inner] <= prev_pos;
      inner <= inner - 1'b1;
    end
    if (cmd.place_cur) begin
      order_mem[inner] <= outer[IdxBits-1:0];
    end
    emit_pos <= order_mem[cmd.emit_step ? IdxBits'(emit_idx + 1'b1)
                                        : emit_idx[IdxBits-1:0]];
  end

  // Previous entry is fetched from the store in the cycle after its position.
  always_ff @(posedge clk) begin
    prev_ent <= store_mem[prev_pos];
  end

  // Sort comparison: is prev strictly after cur, by source node, then angle?
  logic [NODE_BITS-1:0]         ps, cs;
  logic signed [COORD_BITS-1:0] px, py, cx, cy;
  logic                         pz, cz;
  logic                         ph, ch;
  logic signed [ProdBits-1:0]   prod_p, prod_q;
  logic                         greater;

  always_comb begin
    {ps, px, py} = prev_ent;
    {cs, cx, cy} = cur_ent;
    pz = (px == '0) && (py == '0);
    cz = (cx == '0) && (cy == '0);
    // Upper half plane (angles in [0,180)) flag.
    ph = (py != '0) ? !py[COORD_BITS-1] : !px[COORD_BITS-1];
    ch = (cy != '0) ? !cy[COORD_BITS-1] : !cx[COORD_BITS-1];
    prod_p = cx * py;
    prod_q = px * cy;
    if (ps != cs) begin
      greater = ps > cs;
    end else if ((px == cx) && (py == cy)) begin
      greater = 1'b0;
    end else if (pz) begin
      greater = 1'b0;
    end else if (cz) begin
      greater = 1'b1;
    end else if (ph != ch) begin
      greater = ch;
    end else begin
      greater = prod_p > prod_q;
    end
  end

  // Status back to the controller; the compare result is sampled only in
  // the cycle after the previous entry has been fetched.
  always_comb begin
    status.full          = (count == CntBits'(MAX_EDGES));
    status.outer_done    = (outer == count);
    status.inner_at_zero = (inner == '0);
    status.prev_greater  = greater;
    status.emit_last     = (emit_idx + 1'b1 == count);
  end

  assign out_pos = eas_pkg::PosBits'(emit_pos);
  assign out_ovf = ovf;

endmodule
`default_nettype wire

// ===== hdl/eas_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eas_controller
// Sequencer of load, insertion sort and emit phases.
// ----------------------------------------------------------------------------
module eas_controller (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_last,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_last,
  input  wire eas_pkg::eas_status_t status,
  output eas_pkg::eas_cmd_t         cmd
);
  eas_pkg::eas_state_t state, state_next;
  logic [1:0] phase, phase_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eas_pkg::ST_LOAD;
      phase <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    out_last   = 1'b0;
    case (state)
      eas_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store_edge   = !status.full;
          cmd.set_overflow = status.full;
          if (in_last) begin
            cmd.start_sort = 1'b1;
            state_next     = eas_pkg::ST_SORT_READ;
            phase_next     = '0;
          end
        end
      end
      eas_pkg::ST_SORT_READ: begin
        // phase 0: fetch the current entry, or finish sorting.
        if (status.outer_done) begin
          cmd.start_emit = 1'b1;
          state_next     = eas_pkg::ST_EMIT;
          phase_next     = '0;
        end else begin
          cmd.load_cur = 1'b1;
          state_next   = eas_pkg::ST_SORT_CMP;
          phase_next   = '0;
        end
      end
      eas_pkg::ST_SORT_CMP: begin
        // phase 0 decide/read prev, 1 fetch entry, 2 compare.
        case (phase)
          2'd0: begin
            if (status.inner_at_zero) begin
              cmd.place_cur  = 1'b1;
              cmd.next_outer = 1'b1;
              state_next     = eas_pkg::ST_SORT_READ;
            end else begin
              cmd.read_prev = 1'b1;
              phase_next    = 2'd1;
            end
          end
          2'd1: phase_next = 2'd2;
          2'd2: begin
            phase_next = 2'd0;
            if (status.prev_greater) begin
              cmd.shift_order = 1'b1;
            end else begin
              cmd.place_cur  = 1'b1;
              cmd.next_outer = 1'b1;
              state_next     = eas_pkg::ST_SORT_READ;
            end
          end
          default: phase_next = 2'd0;
        endcase
      end
      eas_pkg::ST_EMIT: begin
        // A setup phase after entry lets the registered order read settle.
        if (phase == 2'd0) begin
          phase_next = 2'd1;
        end else begin
          out_valid = 1'b1;
          out_last  = status.emit_last;
          if (out_ready) begin
            cmd.emit_step = 1'b1;
            if (status.emit_last) begin
              cmd.clear_set = 1'b1;
              state_next    = eas_pkg::ST_LOAD;
              phase_next    = '0;
            end
          end
        end
      end
      default: state_next = eas_pkg::ST_LOAD;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/edge_angle_sorter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// edge_angle_sorter
// Stable sort of loaded edges by source node, then counterclockwise angle.
// ----------------------------------------------------------------------------
// Edges are taken one word per cycle until the word marked last_edge; edges
// past MAX_EDGES are dropped and flag overflow. The block then runs an
// insertion sort over the stored edges; each comparison waits on the chained
// registered reads of the order table and then the edge store. Results then
// leave one word per cycle while the receiver is ready, after a setup phase.
// Input is not accepted while sorting or emitting.
module edge_angle_sorter #(
  parameter int MAX_EDGES  = eas_pkg::MaxEdgesDefault,
  parameter int NODE_BITS  = eas_pkg::NodeBitsDefault,
  parameter int COORD_BITS = eas_pkg::CoordBitsDefault
) (
  input wire logic clk,
  input wire logic rst,
  eas_stream_if.sink   in_edge,
  eas_stream_if.source out_result
);
  eas_pkg::eas_cmd_t    cmd;
  eas_pkg::eas_status_t status;
  logic [eas_pkg::PosBits-1:0] pos;
  logic ovf, last;

  eas_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_edge.valid),
    .in_last   (in_edge.data.last_edge),
    .in_ready  (in_edge.ready),
    .out_valid (out_result.valid),
    .out_ready (out_result.ready),
    .out_last  (last),
    .status    (status),
    .cmd       (cmd)
  );

  eas_datapath #(
    .MAX_EDGES  (MAX_EDGES),
    .NODE_BITS  (NODE_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .in_src  (NODE_BITS'(in_edge.data.source_node)),
    .in_x    (COORD_BITS'(in_edge.data.vec_x)),
    .in_y    (COORD_BITS'(in_edge.data.vec_y)),
    .out_pos (pos),
    .out_ovf (ovf)
  );

  // Result word.
  assign out_result.data.edge_position = pos;
  assign out_result.data.overflow      = ovf;
  assign out_result.data.last_result   = last;

endmodule
`default_nettype wire

// ===== hdl/eas_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eas_checker
// Port-level checks of the edge angle sorter.
// ----------------------------------------------------------------------------
module eas_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_last,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last,
  input wire logic out_ovf
);
  // No input is taken while results are pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready during emit");

  // A last input word leads to input being closed next cycle.
  a_close: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input still open after last word");

  // Input reopens right after the final result.
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("input not reopened after run");

  // Overflow is constant over a run.
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && $past(out_valid) && !$past(out_last)) |-> $stable(out_ovf))
    else $error("overflow changed within run");

  // A held result stays.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");
endmodule

bind edge_angle_sorter eas_checker u_eas_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_edge.valid),
  .in_ready  (in_edge.ready),
  .in_last   (in_edge.data.last_edge),
  .out_valid (out_result.valid),
  .out_ready (out_result.ready),
  .out_last  (out_result.data.last_result),
  .out_ovf   (out_result.data.overflow)
);
`default_nettype wire

// ===== verif/edge_angle_sorter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_angle_sorter_test
// Self-checking test of the edge angle sorter.
// ----------------------------------------------------------------------------
// Edge sets are streamed into the block with random idle gaps on both
// channels, which some tests switch off. A behavioral sorter keeps its own
// copy of the loaded edges. On each word marked last_edge it orders them
// by source node, then by counterclockwise angle, keeping load order on
// ties. The expected load positions are queued, and every result word is
// checked against the oldest one.
module edge_angle_sorter_test;

  localparam int MaxEdges  = eas_pkg::MaxEdgesDefault;
  localparam int WatchLimit = 40000;

  typedef struct packed {
    logic [eas_pkg::NodeBitsDefault-1:0]         source_node;
    logic signed [eas_pkg::CoordBitsDefault-1:0] vec_x;
    logic signed [eas_pkg::CoordBitsDefault-1:0] vec_y;
    logic                                        last_edge;
  } edge_word_t;

  typedef struct packed {
    logic [eas_pkg::PosBits-1:0] edge_position;
    logic                        overflow;
    logic                        last_result;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  eas_stream_if #(.T(edge_word_t))   edge_ch ();
  eas_stream_if #(.T(result_word_t)) result_ch ();

  edge_angle_sorter u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_edge   (edge_ch),
    .out_result(result_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the loaded edge set.
  int unsigned          set_src [MaxEdges];
  longint               set_x [MaxEdges];
  longint               set_y [MaxEdges];
  int                   set_count;
  bit                   set_overflow;
  result_word_t         sorted_q[$];

  int  errors;
  int  idle_cycles;
  bit  tx_gaps = 1'b1;
  bit  rx_gaps = 1'b1;
  int  rx_hold;
  int  rx_wait;
  bit  rx_took;

  // Half plane of a non-zero vector: 1 for [0,180) degrees, -1 for [180,360).
  function automatic int half_plane(longint x, longint y);
    if (y != 0) return (y > 0) ? 1 : -1;
    return (x > 0) ? 1 : -1;
  endfunction

  // Positive when edge a sorts after edge b.
  function automatic int edge_after(int a, int b);
    longint p, q;
    int     ha, hb;
    if (set_src[a] != set_src[b]) return (set_src[a] > set_src[b]) ? 1 : -1;
    if (set_x[a] == set_x[b] && set_y[a] == set_y[b]) return 0;
    if (set_x[a] == 0 && set_y[a] == 0) return -1;
    if (set_x[b] == 0 && set_y[b] == 0) return 1;
    ha = half_plane(set_x[a], set_y[a]);
    hb = half_plane(set_x[b], set_y[b]);
    if (ha != hb) return hb - ha;
    p = set_x[b] * set_y[a];
    q = set_x[a] * set_y[b];
    return (p > q) ? 1 : ((p < q) ? -1 : 0);
  endfunction

  // Load one accepted edge and, on the last one, queue the sorted positions.
  task automatic load_edge(edge_word_t w);
    int order[MaxEdges];
    int j;
    result_word_t r;
    if (set_count < MaxEdges) begin
      set_src[set_count] = w.source_node;
      set_x[set_count]   = w.vec_x;
      set_y[set_count]   = w.vec_y;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!w.last_edge) return;
    // Stable insertion sort of the load positions.
    for (int i = 0; i < set_count; i++) begin
      j = i;
      while (j > 0 && edge_after(order[j-1], i) > 0) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (int i = 0; i < set_count; i++) begin
      r.edge_position = order[i][eas_pkg::PosBits-1:0];
      r.overflow      = set_overflow;
      r.last_result   = (i == set_count - 1);
      sorted_q.push_back(r);
    end
    set_count    = 0;
    set_overflow = 1'b0;
  endtask

  // Offer one word, after a random gap when tx_gaps is set, and wait until it is taken.
  task automatic send_edge(int unsigned src, int x, int y, bit last);
    edge_word_t w;
    if (tx_gaps) repeat ($urandom_range(0, 17)) @(negedge clk);
    w.source_node = src[eas_pkg::NodeBitsDefault-1:0];
    w.vec_x       = x[eas_pkg::CoordBitsDefault-1:0];
    w.vec_y       = y[eas_pkg::CoordBitsDefault-1:0];
    w.last_edge   = last;
    edge_ch.data  = w;
    edge_ch.valid = 1'b1;
    do @(posedge clk); while (!edge_ch.ready);
    load_edge(w);
    @(negedge clk);
    edge_ch.valid = 1'b0;
  endtask

  // Random coordinate: full range, extremes or a tiny value for ties.
  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1, 2: return int'($urandom_range(0, 6)) - 3;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Random edge set of the requested size over a chosen span of source nodes.
  task automatic send_random_set(int n);
    int unsigned span;
    span = $urandom_range(0, 3) == 0 ? 1023 : $urandom_range(0, 3);
    for (int i = 0; i < n; i++)
      send_edge(span == 1023 ? $urandom_range(0, 1023) : $urandom_range(0, span) * 341,
                rand_coord(), rand_coord(), i == n - 1);
  endtask

  task automatic test_directed();
    // A single edge, then a set covering axes, quadrants and extremes.
    send_edge(1023, 0, 0, 1'b1);
    send_edge(5, 1, 0, 1'b0);
    send_edge(5, 0, 0, 1'b0);
    send_edge(5, -32768, 0, 1'b0);
    send_edge(5, 0, -32768, 1'b0);
    send_edge(5, 0, 32767, 1'b0);
    send_edge(5, 32767, 32767, 1'b0);
    send_edge(5, -32768, -32768, 1'b0);
    send_edge(5, 32767, -32768, 1'b0);
    send_edge(5, -1, 1, 1'b0);
    send_edge(5, 2, 0, 1'b0);
    send_edge(5, 1, 0, 1'b0);
    send_edge(5, 0, 0, 1'b0);
    send_edge(0, -5, -1, 1'b0);
    send_edge(0, 3, -1, 1'b0);
    send_edge(1023, 32767, -1, 1'b0);
    send_edge(1023, 32767, 1, 1'b0);
    send_edge(1023, -32768, 1, 1'b1);
  endtask

  task automatic test_overflow();
    // Extra edges dropped before a dropped last one, then a set where only the last edge is dropped, then a full set.
    for (int i = 0; i < MaxEdges + 3; i++)
      send_edge($urandom_range(0, 3), rand_coord(), rand_coord(), i == MaxEdges + 2);
    for (int i = 0; i <= MaxEdges; i++)
      send_edge($urandom_range(0, 1023), rand_coord(), rand_coord(), i == MaxEdges);
    send_random_set(MaxEdges);
  endtask

  task automatic test_backpressure();
    // The receiver holds off past the whole sort while whole sets keep coming.
    tx_gaps = 1'b0;
    rx_hold = 3000;
    send_random_set(30);
    send_random_set(5);
    tx_gaps = 1'b1;
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 250) begin
      automatic int n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, MaxEdges)
                                                     : $urandom_range(1, 12);
      if ($urandom_range(0, 7) == 0) begin
        tx_gaps = ~tx_gaps;
        rx_gaps = ~rx_gaps;
      end
      send_random_set(n);
      sent += n;
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // Receiver: drive ready at the falling edge with random holds.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_took) begin
        rx_took = 1'b0;
        rx_wait = rx_gaps ? $urandom_range(0, 17) : 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        result_ch.ready = 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        result_ch.ready = 1'b0;
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  // Check each result word and watch for a hung run.
  always @(posedge clk) begin
    result_word_t got, want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      rx_took = 1'b1;
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected word: actual %p", $time, got);
        errors++;
      end else begin
        want = sorted_q.pop_front();
        if (got.edge_position !== want.edge_position) begin
          $display("%0t: edge_position expected %0d actual %0d", $time,
                   want.edge_position, got.edge_position);
          errors++;
        end
        if (got.overflow !== want.overflow) begin
          $display("%0t: overflow expected %0b actual %0b", $time,
                   want.overflow, got.overflow);
          errors++;
        end
        if (got.last_result !== want.last_result) begin
          $display("%0t: last_result expected %0b actual %0b", $time,
                   want.last_result, got.last_result);
          errors++;
        end
      end
    end
    if ((edge_ch.valid && edge_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    edge_ch.valid = 1'b0;
    edge_ch.data  = '0;
    set_count = 0;
    set_overflow = 1'b0;
    errors = 0;
    idle_cycles = 0;
    rx_hold = 0;
    rx_wait = 0;
    rx_took = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_overflow();
    test_backpressure();
    test_random();
    wait (sorted_q.size() == 0);
    repeat (50) @(negedge clk);
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
